// ===== rtl/lr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

  // Fixed widths of the stream fields and config registers
  localparam int FieldW = 16;
  localparam int CfgW   = 13;

  // Default coordinate width (valid range 8..16)
  localparam int CoordBitsDef = 16;

  // Depth of the command queue between front and back
  localparam int QueueDepth = 4;

  // Action codes carried in s_tuser
  localparam logic ActStart = 1'b0;
  localparam logic ActCont  = 1'b1;

  // Config register indexes
  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  // Config reset values
  localparam logic [CfgW-1:0] WidthRst  = CfgW'(320);
  localparam logic [CfgW-1:0] HeightRst = CfgW'(240);

  // Classification of one queued command
  typedef struct packed {
    logic start;       // start of a new line (else continue)
    logic zero_len;    // start with equal endpoints
    logic steep;       // major axis is y
    logic minor_down;  // minor coordinate decreases along the walk
  } cmd_flags_t;

endpackage

`default_nettype wire

// ===== rtl/lr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lr_front #(
  parameter int CB = lr_pkg::CoordBitsDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // input side
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_start,
  input  wire logic [CB-1:0]            in_x0,
  input  wire logic [CB-1:0]            in_y0,
  input  wire logic [CB-1:0]            in_x1,
  input  wire logic [CB-1:0]            in_y1,
  input  wire logic [lr_pkg::FieldW-1:0] in_color,
  // queue write side
  output logic                          push,
  input  wire logic                     full,
  output lr_pkg::cmd_flags_t            cmd_flags,
  output logic [CB-1:0]                 cmd_major_pos,
  output logic [CB-1:0]                 cmd_minor_pos,
  output logic [CB-1:0]                 cmd_major_end,
  output logic [CB-1:0]                 cmd_major_delta,
  output logic [CB-1:0]                 cmd_minor_delta,
  output logic [lr_pkg::FieldW-1:0]     cmd_color
);

  // stage 1: abs deltas, steepness, endpoint order
  logic                      s1_valid;
  logic                      s1_start;
  logic [CB-1:0]             s1_x0, s1_y0, s1_x1, s1_y1;
  logic [lr_pkg::FieldW-1:0] s1_color;
  logic [CB-1:0]             s1_adx, s1_ady;
  logic                      s1_steep, s1_swap;

  logic [CB-1:0] adx, ady;
  logic          steep_c, swap_c;

  assign in_ready = !s1_valid || !full;
  assign push     = s1_valid && !full;

  always_comb begin
    adx     = (in_x1 >= in_x0) ? in_x1 - in_x0 : in_x0 - in_x1;
    ady     = (in_y1 >= in_y0) ? in_y1 - in_y0 : in_y0 - in_y1;
    steep_c = ady > adx;
    swap_c  = steep_c ? (in_y0 > in_y1) : (in_x0 > in_x1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_start <= in_start;
      s1_x0    <= in_x0;
      s1_y0    <= in_y0;
      s1_x1    <= in_x1;
      s1_y1    <= in_y1;
      s1_color <= in_color;
      s1_adx   <= adx;
      s1_ady   <= ady;
      s1_steep <= steep_c;
      s1_swap  <= swap_c;
    end
  end

  // stage 2: axis swap and ordering, straight into the queue
  logic [CB-1:0] a_lo, a_hi, b_lo, b_hi, minor_far;

  always_comb begin
    a_lo = s1_steep ? s1_y0 : s1_x0;
    a_hi = s1_steep ? s1_y1 : s1_x1;
    b_lo = s1_steep ? s1_x0 : s1_y0;
    b_hi = s1_steep ? s1_x1 : s1_y1;

    cmd_major_pos   = s1_swap ? a_hi : a_lo;
    cmd_major_end   = s1_swap ? a_lo : a_hi;
    cmd_minor_pos   = s1_swap ? b_hi : b_lo;
    minor_far       = s1_swap ? b_lo : b_hi;
    cmd_major_delta = s1_steep ? s1_ady : s1_adx;
    cmd_minor_delta = s1_steep ? s1_adx : s1_ady;
    cmd_color       = s1_color;

    cmd_flags.start      = s1_start;
    cmd_flags.zero_len   = (s1_adx == '0) && (s1_ady == '0);
    cmd_flags.steep      = s1_steep;
    cmd_flags.minor_down = minor_far < cmd_minor_pos;
  end

endmodule

`default_nettype wire

// ===== rtl/lr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lr_fifo #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   empty
);

  localparam int Depth = lr_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] mem [Depth];
  logic [PtrW-1:0]   wptr, rptr;
  logic [CntW-1:0]   count;

  assign full    = count == CntW'(Depth);
  assign empty   = count == '0;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (rd_en) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + PtrW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
                                  count <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/lr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lr_back #(
  parameter int CB = lr_pkg::CoordBitsDef
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [lr_pkg::CfgW-1:0]   screen_width,
  input  wire logic [lr_pkg::CfgW-1:0]   screen_height,
  // queue read side
  input  wire logic                      cmd_avail,
  output logic                           pop,
  input  wire lr_pkg::cmd_flags_t        cmd_flags,
  input  wire logic [CB-1:0]             cmd_major_pos,
  input  wire logic [CB-1:0]             cmd_minor_pos,
  input  wire logic [CB-1:0]             cmd_major_end,
  input  wire logic [CB-1:0]             cmd_major_delta,
  input  wire logic [CB-1:0]             cmd_minor_delta,
  input  wire logic [lr_pkg::FieldW-1:0] cmd_color,
  // result register
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_valid_res,
  output logic [lr_pkg::FieldW-1:0]      out_x,
  output logic [lr_pkg::FieldW-1:0]      out_y,
  output logic [lr_pkg::FieldW-1:0]      out_color,
  output logic                           out_on_screen,
  output logic                           out_last
);

  localparam int FW = lr_pkg::FieldW;
  localparam int EW = CB + 2;

  // walk state
  logic                 active;
  logic                 steep;
  logic [CB-1:0]        major_pos, minor_pos, major_end;
  logic [CB-1:0]        major_delta, minor_delta;
  logic signed [EW-1:0] error_term;
  logic                 minor_down;
  logic [FW-1:0]        held_color;

  // current pixel: fresh command on start, stored walk otherwise
  logic                 use_cmd, emit, fin;
  logic                 steep_cur, down_cur;
  logic [CB-1:0]        maj_cur, min_cur, end_cur, mdel_cur, ndel_cur;
  logic [FW-1:0]        color_cur;
  logic signed [EW-1:0] err_cur, err_sub, err_next;
  logic [CB-1:0]        min_next, px, py;

  assign pop = cmd_avail && (!out_valid || out_ready);

  always_comb begin
    use_cmd   = cmd_flags.start;
    emit      = cmd_flags.start ? !cmd_flags.zero_len : active;
    steep_cur = use_cmd ? cmd_flags.steep      : steep;
    down_cur  = use_cmd ? cmd_flags.minor_down : minor_down;
    maj_cur   = use_cmd ? cmd_major_pos        : major_pos;
    min_cur   = use_cmd ? cmd_minor_pos        : minor_pos;
    end_cur   = use_cmd ? cmd_major_end        : major_end;
    mdel_cur  = use_cmd ? cmd_major_delta      : major_delta;
    ndel_cur  = use_cmd ? cmd_minor_delta      : minor_delta;
    color_cur = use_cmd ? cmd_color            : held_color;
    err_cur   = use_cmd ? $signed({2'b00, cmd_major_delta >> 1}) : error_term;

    fin     = maj_cur == end_cur;
    err_sub = err_cur - $signed({2'b00, ndel_cur});
    if (err_sub[EW-1]) begin
      err_next = err_sub + $signed({2'b00, mdel_cur});
      min_next = down_cur ? min_cur - CB'(1) : min_cur + CB'(1);
    end else begin
      err_next = err_sub;
      min_next = min_cur;
    end

    px = steep_cur ? min_cur : maj_cur;
    py = steep_cur ? maj_cur : min_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      if (cmd_flags.start && cmd_flags.zero_len) begin
        active <= 1'b0;
      end else if (emit) begin
        active <= !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      steep       <= steep_cur;
      minor_down  <= down_cur;
      major_end   <= end_cur;
      major_delta <= mdel_cur;
      minor_delta <= ndel_cur;
      held_color  <= color_cur;
      major_pos   <= maj_cur + CB'(1);
      minor_pos   <= min_next;
      error_term  <= err_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_valid_res <= emit;
      out_x         <= emit ? FW'(px) : '0;
      out_y         <= emit ? FW'(py) : '0;
      out_color     <= emit ? color_cur : '0;
      out_on_screen <= emit && (FW'(px) < FW'(screen_width)) &&
                       (FW'(py) < FW'(screen_height));
      out_last      <= emit && fin;
    end
  end

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_valid_res |->
        out_x == '0 && out_y == '0 && out_color == '0 && !out_on_screen && !out_last)
    else $error("empty result carries data");
  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_last |-> out_valid_res)
    else $error("last flag without a pixel");
  a_active_nonzero: assert property (@(posedge clk) disable iff (rst)
      active |-> major_delta != '0)
    else $error("active walk with zero major delta");
  a_fin_ends_walk: assert property (@(posedge clk) disable iff (rst)
      pop && emit && fin |=> !active)
    else $error("walk still active after last pixel");

endmodule

`default_nettype wire

// ===== rtl/line_rasterizer_top.sv =====
// Bresenham line rasterizer. A start transaction (s_tuser = 0) carries two endpoints and an
// RGB565 color; each continue transaction (s_tuser = 1) steps to the next pixel. Every input
// transaction yields exactly one output transaction: m_tuser[0] says whether a pixel was
// produced (a zero-length start or a continue with no line running gives an all-zero result),
// m_tuser[1] says the pixel lies inside the configured screen, and m_tlast marks the final
// pixel. Both endpoints are drawn. Throughput is one pixel per clock, sustained while commands
// are queued and m_tready is high, set by the error-term step in the back end (one subtract,
// one conditional add). An input transaction passes three registers in order: the front
// classify register, the command queue and the result register.
// The four-entry queue lets the front keep taking input while the output side stalls.
// Write screen_width/screen_height only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_top #(
  parameter int COORD_BITS = lr_pkg::CoordBitsDef
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // config write port
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [lr_pkg::CfgW-1:0]   cfg_data,
  // input stream
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [79:0]               s_tdata,  // start_x, start_y, end_x, end_y, line_color
  input  wire logic [0:0]                s_tuser,  // action
  // output stream
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [47:0]                    m_tdata,  // pixel_x, pixel_y, pixel_color
  output logic [1:0]                     m_tuser,  // valid_res, on_screen
  output logic                           m_tlast   // last
);

  localparam int CB     = COORD_BITS;
  localparam int FW     = lr_pkg::FieldW;
  localparam int FlagW  = $bits(lr_pkg::cmd_flags_t);
  localparam int QDataW = FlagW + 5 * CB + FW;

  // config registers
  logic [lr_pkg::CfgW-1:0] screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lr_pkg::WidthRst;
      screen_height <= lr_pkg::HeightRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lr_pkg::RegWidth:  screen_width  <= cfg_data;
        lr_pkg::RegHeight: screen_height <= cfg_data;
        default:           screen_width  <= screen_width;
      endcase
    end
  end

  // front end: classify input transactions
  logic               push, q_full, q_empty, pop;
  lr_pkg::cmd_flags_t f_flags, b_flags;
  logic [CB-1:0]      f_maj, f_min, f_end, f_mdel, f_ndel;
  logic [CB-1:0]      b_maj, b_min, b_end, b_mdel, b_ndel;
  logic [FW-1:0]      f_color, b_color;
  logic [QDataW-1:0]  q_wr, q_rd;

  lr_front #(.CB(CB)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_start        (s_tuser[0] == lr_pkg::ActStart),
    .in_x0           (s_tdata[0 +: CB]),
    .in_y0           (s_tdata[FW +: CB]),
    .in_x1           (s_tdata[2*FW +: CB]),
    .in_y1           (s_tdata[3*FW +: CB]),
    .in_color        (s_tdata[4*FW +: FW]),
    .push            (push),
    .full            (q_full),
    .cmd_flags       (f_flags),
    .cmd_major_pos   (f_maj),
    .cmd_minor_pos   (f_min),
    .cmd_major_end   (f_end),
    .cmd_major_delta (f_mdel),
    .cmd_minor_delta (f_ndel),
    .cmd_color       (f_color)
  );

  assign q_wr = {f_flags, f_maj, f_min, f_end, f_mdel, f_ndel, f_color};

  lr_fifo #(.DATA_W(QDataW)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  assign {b_flags, b_maj, b_min, b_end, b_mdel, b_ndel, b_color} = q_rd;

  // back end: Bresenham walk and result register
  logic          r_valid_res, r_on, r_last;
  logic [FW-1:0] r_x, r_y, r_color;

  lr_back #(.CB(CB)) u_back (
    .clk             (clk),
    .rst             (rst),
    .screen_width    (screen_width),
    .screen_height   (screen_height),
    .cmd_avail       (!q_empty),
    .pop             (pop),
    .cmd_flags       (b_flags),
    .cmd_major_pos   (b_maj),
    .cmd_minor_pos   (b_min),
    .cmd_major_end   (b_end),
    .cmd_major_delta (b_mdel),
    .cmd_minor_delta (b_ndel),
    .cmd_color       (b_color),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_valid_res   (r_valid_res),
    .out_x           (r_x),
    .out_y           (r_y),
    .out_color       (r_color),
    .out_on_screen   (r_on),
    .out_last        (r_last)
  );

  assign m_tdata = {r_color, r_y, r_x};
  assign m_tuser = {r_on, r_valid_res};
  assign m_tlast = r_last;

endmodule

`default_nettype wire
